// ----- hw/rtl/cpr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants, types and helpers for the clock page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int FRAMES    = 16;
  localparam int IDX_W     = $clog2(FRAMES);
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int PAGE_W    = 16;
  localparam int FAULT_W   = 32;
  localparam int CFG_W     = 5;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 2;

  localparam logic [APB_AW-1:0]  ADDR_FRAMES_IN_USE = APB_AW'(0);
  localparam logic [CFG_W-1:0]   FRAMES_RESET       = CFG_W'(16);
  localparam logic [FAULT_W-1:0] FAULT_MAX          = {FAULT_W{1'b1}};

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Step the hand by one, wrapping at the managed frame count.
  function automatic idx_t next_slot(input idx_t h, input cnt_t m);
    cnt_t t;
    t = cnt_t'(h) + cnt_t'(1);
    return (t >= m) ? idx_t'(0) : t[IDX_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/cpr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/cpr_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_cfg
// APB register file: frames_in_use, plus the clamped active frame count.
// ----------------------------------------------------------------------------
module cpr_cfg import cpr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cnt_t              active
);

  logic [CFG_W-1:0] frames_in_use;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_FRAMES_IN_USE) begin
      frames_in_use <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_FRAMES_IN_USE) begin
      prdata = APB_DW'(frames_in_use);
    end
  end

  // Clamp into 1..FRAMES
  always_comb begin
    priority if (frames_in_use == '0) begin
      active = cnt_t'(1);
    end else if (32'(frames_in_use) > FRAMES) begin
      active = cnt_t'(FRAMES);
    end else begin
      active = cnt_t'(frames_in_use);
    end
  end

endmodule

// ----- hw/rtl/cpr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_ctrl
// Sequencer: serial hit scan over the page RAM, hand sweep, frame load.
// ----------------------------------------------------------------------------
module cpr_ctrl import cpr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cnt_t               active,
  input  logic               start,
  input  logic [PAGE_W-1:0]  page_number,
  output logic               busy,
  output logic               done,
  output logic               hit,
  output logic [IDX_W-1:0]   frame_index,
  output logic               replaced_valid,
  output logic [PAGE_W-1:0]  replaced_page,
  output logic [FAULT_W-1:0] fault_total,
  output logic               ram_we,
  output idx_t               ram_waddr,
  output logic [PAGE_W-1:0]  ram_wdata,
  output idx_t               ram_raddr,
  input  logic [PAGE_W-1:0]  ram_rdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;

  logic [2:0]         state;
  logic [PAGE_W-1:0]  page_q;
  cnt_t               cnt;
  logic               cmp_vld;
  idx_t               cmp_idx;
  idx_t               hand;
  logic [FRAMES-1:0]  valid;
  logic [FRAMES-1:0]  used;
  logic [FAULT_W-1:0] fault_count;
  logic               match;

  assign busy  = (state != ST_IDLE);
  assign match = cmp_vld && valid[cmp_idx] && (ram_rdata == page_q);

  assign ram_raddr = (state == ST_SCAN) ? cnt[IDX_W-1:0] : hand;
  assign ram_we    = (state == ST_LOAD);
  assign ram_waddr = hand;
  assign ram_wdata = page_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      valid       <= '0;
      used        <= '0;
      hand        <= '0;
      fault_count <= '0;
      cmp_vld     <= 1'b0;
      cnt         <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            page_q  <= page_number;
            cnt     <= '0;
            cmp_vld <= 1'b0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // read issued at cnt, compared in the next cycle at cmp_idx
          if (cnt < active) begin
            cnt     <= cnt + cnt_t'(1);
            cmp_vld <= 1'b1;
            cmp_idx <= cnt[IDX_W-1:0];
          end else begin
            cmp_vld <= 1'b0;
          end
          priority if (match) begin
            used[cmp_idx]  <= 1'b1;
            done           <= 1'b1;
            hit            <= 1'b1;
            frame_index    <= cmp_idx;
            replaced_valid <= 1'b0;
            replaced_page  <= '0;
            fault_total    <= fault_count;
            state          <= ST_IDLE;
          end else if (!cmp_vld && cnt >= active) begin
            if (fault_count != FAULT_MAX) begin
              fault_count <= fault_count + FAULT_W'(1);
            end
            if (cnt_t'(hand) >= active) begin
              hand <= '0;
            end
            state <= ST_SWEEP;
          end else begin
          end
        end
        ST_SWEEP: begin
          // second chance: clear and skip, else read victim page
          if (used[hand]) begin
            used[hand] <= 1'b0;
            hand       <= next_slot(hand, active);
          end else begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          valid[hand]    <= 1'b1;
          used[hand]     <= 1'b1;
          hand           <= next_slot(hand, active);
          done           <= 1'b1;
          hit            <= 1'b0;
          frame_index    <= hand;
          replaced_valid <= valid[hand];
          replaced_page  <= valid[hand] ? ram_rdata : '0;
          fault_total    <= fault_count;
          state          <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/clock_page_replacement_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_page_replacement_top
// Clock (second-chance) page replacement over a small set of frames.
// ----------------------------------------------------------------------------
//
// Channel   | Handshake                          | Payload
// ----------+------------------------------------+------------------------------
// request   | start & !busy accepts an item      | page_number
// result    | done, one cycle, cannot be stalled | hit, frame_index,
//           |                                    | replaced_valid, replaced_page,
//           |                                    | fault_total
// config    | APB, write on psel&penable&pwrite  | paddr, pwdata, prdata
//
// Sequence: a hit is found by a serial scan of the page RAM, one frame per
// cycle (M = active frames), each read registered before its compare; the
// scan stops at the matching frame. A miss runs the full scan, then the hand
// sweep, which looks at frames in turn and clears set used bits until it
// finds a clear one (at most one full turn when every used bit is set), then
// the load state, which writes the new page and registers the result.
// Reset (rst, synchronous): all frames invalid and unused, hand and fault
// count zero, frames_in_use = 16. No clearing pass: valid bits are flops.
// The result is shown for one cycle on done; the receiver cannot stall it.
// A new item may be accepted in the cycle its predecessor's result shows.
//
module clock_page_replacement_top import cpr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // request
  input  logic               start,
  output logic               busy,
  input  logic [PAGE_W-1:0]  page_number,
  // result
  output logic               done,
  output logic               hit,
  output logic [IDX_W-1:0]   frame_index,
  output logic               replaced_valid,
  output logic [PAGE_W-1:0]  replaced_page,
  output logic [FAULT_W-1:0] fault_total,
  // config
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  cnt_t              active;
  logic              ram_we;
  idx_t              ram_waddr;
  idx_t              ram_raddr;
  logic [PAGE_W-1:0] ram_wdata;
  logic [PAGE_W-1:0] ram_rdata;

  // register file, yields the clamped frame count
  cpr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .active  (active)
  );

  // page numbers per frame; contents only meaningful where the frame is valid
  cpr_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // scan / sweep / load sequencer; holds valid and used bits, hand, counter
  cpr_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .active         (active),
    .start          (start),
    .page_number    (page_number),
    .busy           (busy),
    .done           (done),
    .hit            (hit),
    .frame_index    (frame_index),
    .replaced_valid (replaced_valid),
    .replaced_page  (replaced_page),
    .fault_total    (fault_total),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

endmodule

// ----- hw/rtl/cpr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_checker
// Port-level checks for the clock page replacement block, bound to the top.
// ----------------------------------------------------------------------------
module cpr_checker import cpr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               done,
  input  logic               hit,
  input  logic               replaced_valid,
  input  logic [PAGE_W-1:0]  replaced_page,
  input  logic [FAULT_W-1:0] fault_total
);

  // an accepted item keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // a result only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an item in flight");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> !replaced_valid)
    else $error("hit reported an eviction");

  // no eviction means a zero evicted page
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    done && !replaced_valid |-> replaced_page == '0)
    else $error("evicted page nonzero without eviction");

  // a fault always leaves a nonzero count
  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> fault_total != '0)
    else $error("fault not counted");

endmodule

bind clock_page_replacement_top cpr_checker u_cpr_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .hit            (hit),
  .replaced_valid (replaced_valid),
  .replaced_page  (replaced_page),
  .fault_total    (fault_total)
);
